// ----- rtl/core/scp_pkg.sv -----
// Shared types and constants for the serial configuration command parser.
// Used by scp_regs, scp_core and serial_config_command_parser; depends on nothing.
`default_nettype none

package scp_pkg;

	// Input item kinds carried on s_tuser. Code 3 has no meaning and is ignored.
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	// Register indexes, taken from paddr[2].
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_HEADER  = 1'b1;

	localparam int          PADDR_W     = 3;
	localparam logic [23:0] TIMEOUT_RST = 24'd5000;
	localparam logic [31:0] HEADER_RST  = 32'h4346_473A;   // "CFG:"
	localparam logic [23:0] TICK_MAX    = 24'hFF_FFFF;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	// Field indexes in the number phase.
	localparam logic [3:0] FIELD_SRC_LAST  = 4'd3;
	localparam logic [3:0] FIELD_PORT_LAST = 4'd6;
	localparam logic [3:0] FIELD_SRV_LAST  = 4'd10;
	localparam logic [3:0] FIELD_END       = 4'd12;
	localparam logic [1:0] GROUP_LAST      = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SYNC = 2'd1,
		PH_NUM  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [23:0] timeout_ticks;
		logic [31:0] header_word;
	} cfg_t;

	// Declared last field first so that echo_valid lands in bit 0 when packed.
	typedef struct packed {
		logic [15:0] server_port;
		logic [31:0] server_address;
		logic [15:0] device_id;
		logic [15:0] dest_port;
		logic [15:0] source_port;
		logic [31:0] source_address;
		logic        timed_out;
		logic        done_res;
		logic        busy_res;
		logic [7:0]  echo_byte;
		logic        echo_valid;
	} res_t;

	localparam int RES_W   = $bits(res_t);
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- rtl/core/scp_regs.sv -----
// Configuration registers of the command parser behind an APB-style port.
// Depends on scp_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module scp_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [scp_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	output scp_pkg::cfg_t                      cfg
);

	logic [23:0] timeout_q;
	logic [31:0] header_q;
	logic        wr_en;
	logic        reg_sel;

	// Registers sit at byte addresses 0 and 4; only bit 2 selects between them.
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= scp_pkg::TIMEOUT_RST;
			header_q  <= scp_pkg::HEADER_RST;
		end else if (wr_en) begin
			if (reg_sel == scp_pkg::REG_TIMEOUT) begin
				timeout_q <= pwdata[23:0];
			end else begin
				header_q <= pwdata;
			end
		end
	end

	always_comb begin
		if (reg_sel == scp_pkg::REG_HEADER) begin
			prdata = header_q;
		end else begin
			prdata = {8'd0, timeout_q};
		end
	end

	assign cfg.timeout_ticks = timeout_q;
	assign cfg.header_word   = header_q;

endmodule

`default_nettype wire

// ----- rtl/core/scp_core.sv -----
// Parser state and its combinational update for one request.
// Depends on scp_pkg for phase_t, cfg_t, res_t and character constants.
`default_nettype none

module scp_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [1:0]    kind,
	input  wire logic [7:0]    rx_byte,
	input  scp_pkg::cfg_t      cfg,
	output scp_pkg::res_t      res
);

	scp_pkg::phase_t phase_q, phase_d;
	logic [1:0]  group_q, group_d;
	logic [23:0] hdr_q, hdr_d;
	logic [3:0]  field_q, field_d;
	logic [15:0] acc_q, acc_d;
	logic [23:0] ticks_q, ticks_d;
	logic [31:0] src_q, src_d;
	logic [31:0] srv_q, srv_d;
	logic [15:0] ports_q [4];
	logic [15:0] ports_d [4];
	logic        done_q, done_d;
	logic        tmo_q, tmo_d;
	logic        echo_v;
	logic [7:0]  echo_b;
	logic [23:0] tick_inc;
	logic [15:0] acc_next;

	assign tick_inc = (ticks_q < scp_pkg::TICK_MAX) ? ticks_q + 24'd1 : ticks_q;
	// acc*10 as two shifts, then the digit offset; all modulo 2^16.
	assign acc_next = (acc_q << 3) + (acc_q << 1) + {8'd0, rx_byte}
		- {8'd0, scp_pkg::CHAR_ZERO};

	always_comb begin
		phase_d = phase_q;
		group_d = group_q;
		hdr_d   = hdr_q;
		field_d = field_q;
		acc_d   = acc_q;
		ticks_d = ticks_q;
		src_d   = src_q;
		srv_d   = srv_q;
		ports_d = ports_q;
		done_d  = done_q;
		tmo_d   = tmo_q;
		echo_v  = 1'b0;
		echo_b  = 8'd0;
		case (kind)
			scp_pkg::KIND_START: begin
				phase_d = scp_pkg::PH_SYNC;
				group_d = 2'd0;
				hdr_d   = 24'd0;
				field_d = 4'd0;
				acc_d   = 16'd0;
				ticks_d = 24'd0;
				done_d  = 1'b0;
				tmo_d   = 1'b0;
			end
			scp_pkg::KIND_TICK: begin
				if (phase_q != scp_pkg::PH_IDLE) begin
					ticks_d = tick_inc;
					if (tick_inc > cfg.timeout_ticks) begin
						phase_d = scp_pkg::PH_IDLE;
						tmo_d   = 1'b1;
						ticks_d = 24'd0;
					end
				end
			end
			scp_pkg::KIND_BYTE: begin
				if (phase_q == scp_pkg::PH_SYNC) begin
					ticks_d = 24'd0;
					if (group_q != scp_pkg::GROUP_LAST) begin
						hdr_d   = {hdr_q[15:0], rx_byte};
						group_d = group_q + 2'd1;
					end else begin
						echo_v = 1'b1;
						echo_b = rx_byte;
						if ({hdr_q, rx_byte} == cfg.header_word) begin
							phase_d = scp_pkg::PH_NUM;
							field_d = 4'd0;
							acc_d   = 16'd0;
						end
						group_d = 2'd0;
						hdr_d   = 24'd0;
					end
				end else if (phase_q == scp_pkg::PH_NUM) begin
					ticks_d = 24'd0;
					if (rx_byte == scp_pkg::CHAR_COMMA) begin
						if (field_q <= scp_pkg::FIELD_SRC_LAST) begin
							src_d = {src_q[23:0], acc_q[7:0]};
						end else if (field_q <= scp_pkg::FIELD_PORT_LAST) begin
							// Fields four to six map to ports 0..2 through their low bits.
							ports_d[field_q[1:0]] = acc_q;
						end else if (field_q <= scp_pkg::FIELD_SRV_LAST) begin
							srv_d = {srv_q[23:0], acc_q[7:0]};
						end else begin
							ports_d[3] = acc_q;
							done_d     = 1'b1;
							phase_d    = scp_pkg::PH_IDLE;
						end
						field_d = field_q + 4'd1;
						acc_d   = 16'd0;
					end else begin
						acc_d = acc_next;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= scp_pkg::PH_IDLE;
			group_q <= 2'd0;
			hdr_q   <= 24'd0;
			field_q <= 4'd0;
			acc_q   <= 16'd0;
			ticks_q <= 24'd0;
			src_q   <= 32'd0;
			srv_q   <= 32'd0;
			ports_q <= '{default: 16'd0};
			done_q  <= 1'b0;
			tmo_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			group_q <= group_d;
			hdr_q   <= hdr_d;
			field_q <= field_d;
			acc_q   <= acc_d;
			ticks_q <= ticks_d;
			src_q   <= src_d;
			srv_q   <= srv_d;
			ports_q <= ports_d;
			done_q  <= done_d;
			tmo_q   <= tmo_d;
		end
	end

	always_comb begin
		res.echo_valid     = echo_v;
		res.echo_byte      = echo_b;
		res.busy_res       = (phase_d != scp_pkg::PH_IDLE);
		res.done_res       = done_d;
		res.timed_out      = tmo_d;
		res.source_address = src_d;
		res.source_port    = ports_d[0];
		res.dest_port      = ports_d[1];
		res.device_id      = ports_d[2];
		res.server_address = srv_d;
		res.server_port    = ports_d[3];
	end

	// A finished parse leaves the parser idle until the next start.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> phase_q == scp_pkg::PH_IDLE)
		else $error("done set while a parse is running");

	// A parse either completes or times out, never both.
	a_done_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && tmo_q))
		else $error("done and timeout set together");

	// The field index never runs past the end of the command.
	a_field_rng: assert property (@(posedge clk) disable iff (!arst_n)
		field_q <= scp_pkg::FIELD_END)
		else $error("field index out of range");

	// A tick never moves the parser out of idle.
	a_tick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == scp_pkg::KIND_TICK && phase_q == scp_pkg::PH_IDLE
		|=> phase_q == scp_pkg::PH_IDLE)
		else $error("tick left the idle phase");

endmodule

`default_nettype wire

// ----- rtl/core/serial_config_command_parser.sv -----
// Top level of the serial configuration command parser: input register,
// output register and stream handshakes. Instantiates scp_regs and scp_core.
//
//  channel   dir  handshake                    payload
//  s_*       in   s_tvalid / s_tready          s_tuser kind, s_tdata rx_byte
//  m_*       out  m_tvalid / m_tready          m_tdata result fields
//  apb       in   psel, penable, pwrite        paddr, pwdata, prdata
//
// One request per cycle sustained while m_tready stays high; the input register
// loads at the accepting edge and the state update is then registered in the
// output register, which drives m_tvalid.
// While a result waits on m_tready the input register holds one more request,
// then s_tready drops until the result is taken.
// Reset (arst_n low) empties both registers and returns the parser to idle.
`default_nettype none

module serial_config_command_parser (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [7:0]                          s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]                          s_tuser,   // [1:0] kind
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [0] echo_valid, [8:1] echo_byte, [9] busy_res, [10] done_res,
	// [11] timed_out, [43:12] source_address, [59:44] source_port,
	// [75:60] dest_port, [91:76] device_id, [123:92] server_address,
	// [139:124] server_port, [143:140] zero
	output logic [scp_pkg::TDATA_W-1:0]              m_tdata,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [scp_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [31:0]                         pwdata,
	output logic      [31:0]                         prdata,
	output logic                                     pready
);

	scp_pkg::cfg_t cfg;
	scp_pkg::res_t res;

	logic                          valid_s1;
	logic [1:0]                    kind_s1;
	logic [7:0]                    byte_s1;
	logic                          tvalid_q;
	logic [scp_pkg::RES_W-1:0]     tdata_q;
	logic                          load_out;
	logic                          step;
	logic                          in_acc;

	assign load_out = !tvalid_q || m_tready;
	assign step     = valid_s1 && load_out;
	assign s_tready = !valid_s1 || load_out;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			tvalid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (load_out) begin
				tvalid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
		if (step) begin
			tdata_q <= res;
		end
	end

	scp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.kind    (kind_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign m_tvalid = tvalid_q;
	assign m_tdata  = {{(scp_pkg::TDATA_W - scp_pkg::RES_W){1'b0}}, tdata_q};

endmodule

`default_nettype wire
